// ===== rtl/imh_pkg.sv =====
// Shared types and constants of the indexed max-heap.
package imh_pkg;

  localparam int unsigned VW = 10;
  localparam int unsigned KW = 32;
  localparam int unsigned NUM_VERTICES = 1024;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W = 11;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_DELETE   = 2'd1,
    CMD_INCREASE = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_ABSENT    = 3'd3,
    ST_DUPLICATE = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_LK_POS,
    S_LK_ENT,
    S_DEL_LAST,
    S_UP_RD,
    S_UP_CMP,
    S_DN_L,
    S_DN_R,
    S_DN_C,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [VW-1:0]        vertex;
    logic signed [KW-1:0] key;
  } entry_t;

  localparam int unsigned ENTRY_W = VW + KW;

endpackage

// ===== rtl/indexed_max_heap.sv =====
// Top level of the indexed max-heap priority queue with its sequencer.
//
// The block keeps a binary max-heap of (vertex, key) entries. An input transfer
// carries a command (insert, delete max, increase key, clear), a vertex and a
// key; every command produces exactly one result transfer with a status, the
// removed vertex, the vertex at the root, an empty flag and the entry count.
// Both channels use valid and stall; a transfer happens when valid is high and
// stall is low. One command is worked on at a time: clear and rejected
// commands need no walk through the heap, delete max walks down from the
// root level by level, and insert and increase key walk up level by level.
// The walk is paced by the single read port of the heap memory, which is
// read once per level on the way up and twice (both children) on the way
// down.
// After reset the position memory is swept once, one entry per cycle, through
// all 1024 entries while the input stall is held high. The result sits in an
// output register; while the receiver stalls it the next command is still
// accepted and worked on, and only its final step waits for the register.
module indexed_max_heap #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     command_i,
  input  logic [imh_pkg::VW-1:0]         vertex_i,
  input  logic signed [imh_pkg::KW-1:0]  key_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [imh_pkg::STATUS_W-1:0]   status_o,
  output logic [imh_pkg::VW-1:0]         removed_vertex_o,
  output logic [imh_pkg::VW-1:0]         top_vertex_o,
  output logic                           heap_empty_o,
  output logic [imh_pkg::COUNT_W-1:0]    entry_count_o
);

  // Index width of a heap slot and width of the entry count.
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = IW + 2;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  imh_pkg::state_e state_q, state_d;
  imh_pkg::cmd_e   cmd_q, cmd_d;
  imh_pkg::entry_t ent_q, ent_d;
  imh_pkg::entry_t left_q, left_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic [IW-1:0]   pos_q, pos_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [imh_pkg::VW-1:0] top_q, top_d;
  logic [imh_pkg::VW-1:0] rem_q, rem_d;
  logic [imh_pkg::VW-1:0] init_q, init_d;
  imh_pkg::status_e stat_q, stat_d;

  // Output register.
  logic                          out_valid_q, out_valid_d;
  logic [imh_pkg::STATUS_W-1:0]  out_status_q, out_status_d;
  logic [imh_pkg::VW-1:0]        out_rem_q, out_rem_d;
  logic [imh_pkg::VW-1:0]        out_top_q, out_top_d;
  logic                          out_empty_q, out_empty_d;
  logic [imh_pkg::COUNT_W-1:0]   out_cnt_q, out_cnt_d;

  // Memory ports.
  logic                          h_we;
  logic [IW-1:0]                 h_waddr, h_raddr;
  logic [imh_pkg::ENTRY_W-1:0]   h_wdata, h_rdata_raw;
  imh_pkg::entry_t               h_rdata;
  logic                          p_we;
  logic [imh_pkg::VW-1:0]        p_waddr, p_raddr;
  logic [IW-1:0]                 p_wdata, p_rdata;

  // One write of an entry into a heap slot, mirrored in the position memory.
  logic                          wr_en;
  logic [IW-1:0]                 wr_idx;
  imh_pkg::entry_t               wr_ent;

  logic [IW-1:0]  parent_idx;
  logic [XW-1:0]  l_idx, r_idx;
  logic           l_ok, r_ok, present, out_free;

  imh_ram #(.DEPTH(CAPACITY), .WIDTH(imh_pkg::ENTRY_W)) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata_raw)
  );

  imh_ram #(.DEPTH(imh_pkg::NUM_VERTICES), .WIDTH(IW)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  assign h_rdata = imh_pkg::entry_t'(h_rdata_raw);
  assign h_we    = wr_en;
  assign h_waddr = wr_idx;
  assign h_wdata = wr_ent;

  assign parent_idx = (idx_q - IW'(1)) >> 1;
  assign l_idx      = XW'({idx_q, 1'b1});
  assign r_idx      = l_idx + XW'(1);
  assign l_ok       = l_idx < XW'(cnt_q);
  assign r_ok       = r_idx < XW'(cnt_q);
  // A vertex is present exactly when the slot its position names lies inside
  // the heap and holds that vertex; this makes clear a matter of the count.
  assign present    = (CW'(pos_q) < cnt_q) && (h_rdata.vertex == ent_q.vertex);
  assign out_free   = !out_valid_q || !out_stall_i;

  assign in_stall_o = (state_q != imh_pkg::S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    ent_d   = ent_q;
    left_d  = left_q;
    idx_d   = idx_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    stat_d  = stat_q;
    init_d  = init_q;
    wr_en   = 1'b0;
    wr_idx  = idx_q;
    wr_ent  = ent_q;
    h_raddr = '0;
    p_raddr = vertex_i;
    p_we    = 1'b0;
    p_waddr = '0;
    p_wdata = '0;

    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_rem_d    = out_rem_q;
    out_top_d    = out_top_q;
    out_empty_d  = out_empty_q;
    out_cnt_d    = out_cnt_q;

    unique case (state_q)
      imh_pkg::S_INIT: begin
        p_we    = 1'b1;
        p_waddr = init_q;
        init_d  = init_q + imh_pkg::VW'(1);
        if (init_q == '1) begin
          state_d = imh_pkg::S_IDLE;
        end
      end
      imh_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_d  = imh_pkg::cmd_e'(command_i);
          ent_d  = '{vertex: vertex_i, key: key_i};
          stat_d = imh_pkg::ST_OK;
          rem_d  = '0;
          unique case (imh_pkg::cmd_e'(command_i))
            imh_pkg::CMD_INSERT: begin
              if (cnt_q >= CAP_C) begin
                stat_d  = imh_pkg::ST_FULL;
                state_d = imh_pkg::S_DONE;
              end else begin
                state_d = imh_pkg::S_LK_POS;
              end
            end
            imh_pkg::CMD_INCREASE: begin
              state_d = imh_pkg::S_LK_POS;
            end
            imh_pkg::CMD_DELETE: begin
              if (cnt_q == '0) begin
                stat_d  = imh_pkg::ST_EMPTY;
                state_d = imh_pkg::S_DONE;
              end else begin
                rem_d   = top_q;
                cnt_d   = cnt_q - CW'(1);
                h_raddr = IW'(cnt_q - CW'(1));
                state_d = (cnt_q == CW'(1)) ? imh_pkg::S_DONE : imh_pkg::S_DEL_LAST;
              end
            end
            default: begin
              cnt_d   = '0;
              state_d = imh_pkg::S_DONE;
            end
          endcase
        end
      end
      imh_pkg::S_LK_POS: begin
        pos_d   = p_rdata;
        h_raddr = p_rdata;
        state_d = imh_pkg::S_LK_ENT;
      end
      imh_pkg::S_LK_ENT: begin
        if (cmd_q == imh_pkg::CMD_INSERT) begin
          if (present) begin
            stat_d  = imh_pkg::ST_DUPLICATE;
            state_d = imh_pkg::S_DONE;
          end else begin
            idx_d   = IW'(cnt_q);
            cnt_d   = cnt_q + CW'(1);
            state_d = imh_pkg::S_UP_RD;
          end
        end else begin
          if (!present) begin
            stat_d  = imh_pkg::ST_ABSENT;
            state_d = imh_pkg::S_DONE;
          end else begin
            idx_d   = pos_q;
            state_d = imh_pkg::S_UP_RD;
          end
        end
      end
      imh_pkg::S_DEL_LAST: begin
        ent_d   = h_rdata;
        idx_d   = '0;
        state_d = imh_pkg::S_DN_L;
      end
      imh_pkg::S_UP_RD: begin
        if (idx_q == '0) begin
          wr_en   = 1'b1;
          state_d = imh_pkg::S_DONE;
        end else begin
          h_raddr = parent_idx;
          state_d = imh_pkg::S_UP_CMP;
        end
      end
      imh_pkg::S_UP_CMP: begin
        wr_en = 1'b1;
        if (h_rdata.key >= ent_q.key) begin
          state_d = imh_pkg::S_DONE;
        end else begin
          // The parent moves down into the hole, the hole moves up.
          wr_ent  = h_rdata;
          idx_d   = parent_idx;
          state_d = imh_pkg::S_UP_RD;
        end
      end
      imh_pkg::S_DN_L: begin
        h_raddr = l_idx[IW-1:0];
        state_d = imh_pkg::S_DN_R;
      end
      imh_pkg::S_DN_R: begin
        left_d  = h_rdata;
        h_raddr = r_idx[IW-1:0];
        state_d = imh_pkg::S_DN_C;
      end
      imh_pkg::S_DN_C: begin
        wr_en = 1'b1;
        if (r_ok && (h_rdata.key > ent_q.key) &&
            !(l_ok && (left_q.key >= h_rdata.key))) begin
          wr_ent  = h_rdata;
          idx_d   = r_idx[IW-1:0];
          state_d = imh_pkg::S_DN_L;
        end else if (l_ok && (left_q.key > ent_q.key)) begin
          wr_ent  = left_q;
          idx_d   = l_idx[IW-1:0];
          state_d = imh_pkg::S_DN_L;
        end else begin
          state_d = imh_pkg::S_DONE;
        end
      end
      imh_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = stat_q;
          out_rem_d    = rem_q;
          out_top_d    = (cnt_q != '0) ? top_q : '0;
          out_empty_d  = (cnt_q == '0);
          out_cnt_d    = imh_pkg::COUNT_W'(cnt_q);
          state_d      = imh_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = imh_pkg::S_IDLE;
      end
    endcase

    if (wr_en) begin
      p_we    = 1'b1;
      p_waddr = wr_ent.vertex;
      p_wdata = wr_idx;
    end
  end

  // The root vertex is tracked in a register so that results need no read.
  assign top_d = (wr_en && (wr_idx == '0)) ? wr_ent.vertex : top_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= imh_pkg::S_INIT;
      cnt_q       <= '0;
      init_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    ent_q        <= ent_d;
    left_q       <= left_d;
    idx_q        <= idx_d;
    pos_q        <= pos_d;
    top_q        <= top_d;
    rem_q        <= rem_d;
    stat_q       <= stat_d;
    out_status_q <= out_status_d;
    out_rem_q    <= out_rem_d;
    out_top_q    <= out_top_d;
    out_empty_q  <= out_empty_d;
    out_cnt_q    <= out_cnt_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign removed_vertex_o = out_rem_q;
  assign top_vertex_o     = out_top_q;
  assign heap_empty_o     = out_empty_q;
  assign entry_count_o    = out_cnt_q;

  // The count never passes the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CAP_C)
    else $error("entry count above capacity");

  // A finished command whose result finds the output register free is shown.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == imh_pkg::S_DONE) && out_free |=> out_valid_o)
    else $error("result not presented");

  // The empty flag of a result agrees with its count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (heap_empty_o == (entry_count_o == '0)))
    else $error("empty flag disagrees with count");

  // No command is taken while the position memory is being swept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == imh_pkg::S_INIT) |-> in_stall_o)
    else $error("input accepted during sweep");

endmodule

// ===== rtl/imh_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
module imh_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 42
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
